// ===== rtl/tari_pkg.sv =====
// tari_pkg: shared types and constants of the timestamped angle ring interpolator
// no dependencies
package tari_pkg;

  localparam int unsigned TimeW  = 48;
  localparam int unsigned AngW   = 32;
  localparam int unsigned RangeW = 31;
  localparam int unsigned CountW = 32;
  localparam int unsigned LatW   = 24;
  localparam int unsigned WinW   = 31;
  localparam int unsigned LimW   = 62;
  localparam int unsigned MagW   = 33;
  localparam int unsigned ProdW  = MagW + TimeW;
  localparam int unsigned QuoW   = 34;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 64;

  localparam logic [LatW-1:0] LatencyReset = LatW'(1250000);
  localparam logic [WinW-1:0] WindowReset  = WinW'(6553600);
  localparam logic [LimW-1:0] LimitReset   = LimW'(429497);

  typedef enum logic [1:0] {
    REG_LATENCY = 2'd0,
    REG_WINDOW  = 2'd1,
    REG_LIMIT   = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    FIT_INTERP = 2'd0,
    FIT_EXTRAP = 2'd1,
    FIT_HOLD   = 2'd2,
    FIT_EMPTY  = 2'd3
  } fit_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_PICK,
    ST_MUL,
    ST_DIV,
    ST_SUM,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic [TimeW-1:0]        t;
    logic signed [AngW-1:0]  az;
    logic signed [AngW-1:0]  el;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

// ===== rtl/tari_req_if.sv =====
// tari_req_if, tari_rsp_if: request and result channels with valid/ready
// depends on tari_pkg for field widths
interface tari_req_if;
  import tari_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic [TimeW-1:0]       stamp;
  logic signed [AngW-1:0] azimuth_in;
  logic signed [AngW-1:0] elevation_in;
  logic [RangeW-1:0]      range_in;
  modport source(output valid, req_type, stamp, azimuth_in, elevation_in, range_in,
                 input ready);
  modport sink(input valid, req_type, stamp, azimuth_in, elevation_in, range_in,
               output ready);
endinterface

interface tari_rsp_if;
  import tari_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [AngW-1:0] azimuth_out;
  logic signed [AngW-1:0] elevation_out;
  logic [1:0]             fit_kind;
  logic                   is_still;
  logic [CountW-1:0]      stable_run;
  modport source(output valid, azimuth_out, elevation_out, fit_kind, is_still, stable_run,
                 input ready);
  modport sink(input valid, azimuth_out, elevation_out, fit_kind, is_still, stable_run,
               output ready);
endinterface

// ===== rtl/tari_ram.sv =====
// tari_ram: generic single write port, single read port ram with registered read
// no dependencies
module tari_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== rtl/timestamped_angle_ring_interpolator.sv =====
// timestamped_angle_ring_interpolator: ring of timestamped angle samples with
// linear interpolation, extrapolation and stillness check
// depends on tari_pkg, tari_req_if, tari_rsp_if, tari_ram
// record: the sample is written when taken; ST_RESULT loads the output register once free
// query: walks the n stored samples in the ram (skipped when empty), drains the read pipe,
// picks the fit and, when the fit needs a division, runs the bit-serial multiply and divide
// before the sum and result states; the ram walk reads one entry a cycle
// one request at a time; a new request is taken while a result waits in the output register
// reset clears ring pointers, counters and flags; ring and payload contents stay undefined.
module timestamped_angle_ring_interpolator import tari_pkg::*; #(
  parameter int unsigned RING_DEPTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  tari_req_if.sink         req_i,
  tari_rsp_if.source       rsp_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);
  localparam int unsigned PW = $clog2(RING_DEPTH);
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam logic [PW-1:0] LastSlot = PW'(RING_DEPTH - 1);
  localparam logic [CW-1:0] FullCnt  = CW'(RING_DEPTH);

  // configuration
  logic [LatW-1:0] lat_q;
  logic [WinW-1:0] win_q;
  logic [LimW-1:0] lim_q;
  reg_idx_e        ridx;

  assign pready = 1'b1;
  assign ridx   = reg_idx_e'(paddr[4:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_q <= LatencyReset;
      win_q <= WindowReset;
      lim_q <= LimitReset;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_LATENCY: lat_q <= pwdata[LatW-1:0];
        REG_WINDOW:  win_q <= pwdata[WinW-1:0];
        REG_LIMIT:   lim_q <= pwdata[LimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_LATENCY: prdata = DataW'(lat_q);
      REG_WINDOW:  prdata = DataW'(win_q);
      REG_LIMIT:   prdata = DataW'(lim_q);
      default:     prdata = '0;
    endcase
  end

  // control state
  state_e            state_q, state_d;
  logic [PW-1:0]     wslot_q;
  logic              full_q;
  logic [RangeW-1:0] last_rng_q;
  logic [CountW-1:0] stab_q;
  logic [CW-1:0]     n_q, iss_q;
  logic [PW-1:0]     ptr_q;
  logic [1:0]        drn_q;
  logic [5:0]        mcnt_q;
  logic [6:0]        dcnt_q;
  logic              rvld_q, seen_q, found_q, still_q, div_q;
  logic              s1_vld_q, s1_big_q, s2_vld_q, s2_big_q;

  // payload registers
  logic [TimeW-1:0]        stamp_q;
  entry_t                  e_prev_q, e_last_q, b0_q, b1_q;
  logic [AngW-2:0]         ma_q, me_q;
  logic [LimW-1:0]         sqa_q, sqe_q;
  logic [1:0]              kind_q;
  logic signed [AngW-1:0]  base_az_q, base_el_q;
  logic                    neg_az_q, neg_el_q;
  logic [MagW-1:0]         mag_az_q, mag_el_q;
  logic [TimeW-1:0]        elap_q, span_q;
  logic [ProdW-1:0]        pa_q, pe_q;
  logic [TimeW:0]          ra_q, re_q;
  logic [QuoW-1:0]         qa_q, qe_q;
  logic                    sa_q, se_q;
  logic signed [AngW-1:0]  pend_az_q, pend_el_q;
  logic [1:0]              pend_kind_q;
  logic                    pend_still_q;

  // output register
  logic                    ovld_q;
  logic signed [AngW-1:0]  oaz_q, oel_q;
  logic [1:0]              okind_q;
  logic                    ostill_q;
  logic [CountW-1:0]       orun_q;

  logic accept, is_rec, out_free;
  assign accept   = req_i.valid && req_i.ready;
  assign is_rec   = !req_i.req_type;
  assign out_free = !ovld_q || rsp_o.ready;

  // ring memory
  logic [PW-1:0]     ram_waddr, ram_raddr;
  logic              ram_we;
  entry_t            ram_wdata, ram_rdata;
  logic [EntryW-1:0] ram_rbits;
  logic [TimeW-1:0]  rec_time;

  assign rec_time  = (req_i.stamp >= TimeW'(lat_q)) ? req_i.stamp - TimeW'(lat_q) : '0;
  assign ram_wdata = '{t: rec_time, az: req_i.azimuth_in, el: req_i.elevation_in};
  assign ram_waddr = wslot_q;
  assign ram_raddr = ptr_q;
  assign ram_rdata = entry_t'(ram_rbits);

  tari_ram #(.WIDTH(EntryW), .DEPTH(RING_DEPTH)) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rbits)
  );

  // fit selection
  function automatic logic div_pick();
    logic r;
    r = 1'b0;
    if (n_q != '0) begin
      if (found_q) r = (b1_q.t != b0_q.t);
      else if (n_q >= CW'(2) && stamp_q > e_last_q.t) r = (e_last_q.t > e_prev_q.t);
    end
    return r;
  endfunction

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (is_rec) state_d = ST_RESULT;
          else if (!full_q && wslot_q == '0) state_d = ST_PICK;
          else state_d = ST_WALK;
        end
      end
      ST_WALK:   if (iss_q == n_q - CW'(1)) state_d = ST_DRAIN;
      ST_DRAIN:  if (drn_q == 2'd3) state_d = ST_PICK;
      ST_PICK:   state_d = div_pick() ? ST_MUL : ST_SUM;
      ST_MUL:    if (mcnt_q == 6'(MagW - 1)) state_d = ST_DIV;
      ST_DIV:    if (dcnt_q == 7'(ProdW - 1)) state_d = ST_SUM;
      ST_SUM:    state_d = ST_RESULT;
      ST_RESULT: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_i.ready = (state_q == ST_IDLE);
    ram_we      = (state_q == ST_IDLE) && accept && is_rec;
  end

  assign rsp_o.valid         = ovld_q;
  assign rsp_o.azimuth_out   = oaz_q;
  assign rsp_o.elevation_out = oel_q;
  assign rsp_o.fit_kind      = okind_q;
  assign rsp_o.is_still      = ostill_q;
  assign rsp_o.stable_run    = orun_q;

  logic [1:0]             pk_kind;
  logic signed [AngW-1:0] pk_baz, pk_bel;
  logic signed [MagW-1:0] pk_daz, pk_del;
  logic [TimeW-1:0]       pk_elap, pk_span;

  always_comb begin
    pk_kind = FIT_EMPTY;
    pk_baz  = '0;
    pk_bel  = '0;
    pk_daz  = '0;
    pk_del  = '0;
    pk_elap = '0;
    pk_span = '0;
    if (n_q != '0) begin
      if (found_q) begin
        pk_kind = FIT_INTERP;
        if (b1_q.t == b0_q.t) begin
          pk_baz = b1_q.az;
          pk_bel = b1_q.el;
        end else begin
          pk_baz  = b0_q.az;
          pk_bel  = b0_q.el;
          pk_daz  = MagW'(b1_q.az) - MagW'(b0_q.az);
          pk_del  = MagW'(b1_q.el) - MagW'(b0_q.el);
          pk_elap = stamp_q - b0_q.t;
          pk_span = b1_q.t - b0_q.t;
        end
      end else if (n_q >= CW'(2) && stamp_q > e_last_q.t) begin
        pk_kind = FIT_EXTRAP;
        pk_baz  = e_last_q.az;
        pk_bel  = e_last_q.el;
        pk_daz  = MagW'(e_last_q.az) - MagW'(e_prev_q.az);
        pk_del  = MagW'(e_last_q.el) - MagW'(e_prev_q.el);
        pk_elap = stamp_q - e_last_q.t;
        pk_span = e_last_q.t - e_prev_q.t;
      end else begin
        pk_kind = FIT_HOLD;
        pk_baz  = e_last_q.az;
        pk_bel  = e_last_q.el;
      end
    end
  end

  // walk helpers
  logic signed [MagW-1:0] wda, wde;
  logic [MagW-1:0]        wma, wme;
  logic [LimW:0]          sq_sum;
  assign wda    = MagW'(ram_rdata.az) - MagW'(e_last_q.az);
  assign wde    = MagW'(ram_rdata.el) - MagW'(e_last_q.el);
  assign wma    = wda[MagW-1] ? -wda : wda;
  assign wme    = wde[MagW-1] ? -wde : wde;
  assign sq_sum = {1'b0, sqa_q} + {1'b0, sqe_q};

  // divide step
  logic [TimeW:0] ra_sh, re_sh;
  logic           qa_bit, qe_bit;
  assign ra_sh  = {ra_q[TimeW-1:0], pa_q[ProdW-1]};
  assign re_sh  = {re_q[TimeW-1:0], pe_q[ProdW-1]};
  assign qa_bit = ra_sh >= {1'b0, span_q};
  assign qe_bit = re_sh >= {1'b0, span_q};

  // final add and clamp
  localparam logic [QuoW-1:0] QLim = QuoW'(1) << (QuoW - 1);
  function automatic logic signed [AngW-1:0] fit_sum(
    input logic signed [AngW-1:0] base, input logic neg,
    input logic [QuoW-1:0] q, input logic sat, input logic use_div);
    logic [QuoW-1:0]          qc;
    logic signed [QuoW:0]     off;
    logic signed [QuoW+1:0]   s;
    logic signed [QuoW+1:0]   smax, smin;
    qc   = (sat || q > QLim) ? QLim : q;
    off  = neg ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
    if (!use_div) off = '0;
    s    = $signed((QuoW+2)'(base)) + $signed((QuoW+2)'(off));
    smax = (QuoW+2)'(32'sh7fffffff);
    smin = -(QuoW+2)'(33'sh080000000);
    if (s > smax) return 32'sh7fffffff;
    if (s < smin) return 32'sh80000000;
    return s[AngW-1:0];
  endfunction

  // record stability
  logic signed [RangeW:0] rd;
  logic [RangeW:0]        rmd;
  assign rd  = $signed({1'b0, req_i.range_in}) - $signed({1'b0, last_rng_q});
  assign rmd = rd[RangeW] ? -rd : rd;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      wslot_q    <= '0;
      full_q     <= 1'b0;
      last_rng_q <= '0;
      stab_q     <= '0;
      n_q        <= '0;
      iss_q      <= '0;
      ptr_q      <= '0;
      drn_q      <= '0;
      mcnt_q     <= '0;
      dcnt_q     <= '0;
      rvld_q     <= 1'b0;
      seen_q     <= 1'b0;
      found_q    <= 1'b0;
      still_q    <= 1'b0;
      div_q      <= 1'b0;
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      ovld_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      rvld_q   <= (state_q == ST_WALK);
      s1_vld_q <= rvld_q && seen_q;
      s2_vld_q <= s1_vld_q;
      if (state_q == ST_RESULT && out_free) ovld_q <= 1'b1;
      else if (rsp_o.ready) ovld_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept && is_rec) begin
            if (rmd < {1'b0, win_q}) begin
              if (stab_q != '1) stab_q <= stab_q + CountW'(1);
            end else begin
              stab_q <= '0;
            end
            last_rng_q <= req_i.range_in;
            if (wslot_q == LastSlot) begin
              wslot_q <= '0;
              full_q  <= 1'b1;
            end else begin
              wslot_q <= wslot_q + PW'(1);
            end
          end else if (accept) begin
            n_q     <= full_q ? FullCnt : CW'(wslot_q);
            ptr_q   <= full_q ? wslot_q : '0;
            iss_q   <= '0;
            seen_q  <= 1'b0;
            found_q <= 1'b0;
            still_q <= 1'b1;
            drn_q   <= '0;
          end
        end
        ST_WALK: begin
          iss_q <= iss_q + CW'(1);
          ptr_q <= (ptr_q == LastSlot) ? '0 : ptr_q + PW'(1);
        end
        ST_DRAIN: drn_q <= drn_q + 2'd1;
        ST_PICK: begin
          div_q  <= div_pick();
          mcnt_q <= '0;
        end
        ST_MUL: begin
          mcnt_q <= mcnt_q + 6'd1;
          dcnt_q <= '0;
        end
        ST_DIV: dcnt_q <= dcnt_q + 7'd1;
        default: ;
      endcase
      if (rvld_q) begin
        seen_q <= 1'b1;
        if (seen_q && e_last_q.t <= stamp_q && stamp_q <= ram_rdata.t) found_q <= 1'b1;
      end
      if (s2_vld_q && (s2_big_q || sq_sum > {1'b0, lim_q})) still_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && accept) begin
      stamp_q      <= req_i.stamp;
      pend_az_q    <= '0;
      pend_el_q    <= '0;
      pend_kind_q  <= FIT_INTERP;
      pend_still_q <= 1'b0;
    end
    if (rvld_q) begin
      e_prev_q <= e_last_q;
      e_last_q <= ram_rdata;
      if (seen_q && e_last_q.t <= stamp_q && stamp_q <= ram_rdata.t) begin
        b0_q <= e_last_q;
        b1_q <= ram_rdata;
      end
      s1_big_q <= wma[MagW-1] || wma[MagW-2] || wme[MagW-1] || wme[MagW-2];
      ma_q     <= wma[AngW-2:0];
      me_q     <= wme[AngW-2:0];
    end
    s2_big_q <= s1_big_q;
    sqa_q    <= ma_q * ma_q;
    sqe_q    <= me_q * me_q;
    unique case (state_q)
      ST_PICK: begin
        kind_q    <= pk_kind;
        base_az_q <= pk_baz;
        base_el_q <= pk_bel;
        neg_az_q  <= pk_daz[MagW-1];
        neg_el_q  <= pk_del[MagW-1];
        mag_az_q  <= pk_daz[MagW-1] ? -pk_daz : pk_daz;
        mag_el_q  <= pk_del[MagW-1] ? -pk_del : pk_del;
        elap_q    <= pk_elap;
        span_q    <= pk_span;
        pa_q      <= '0;
        pe_q      <= '0;
        ra_q      <= '0;
        re_q      <= '0;
        qa_q      <= '0;
        qe_q      <= '0;
        sa_q      <= 1'b0;
        se_q      <= 1'b0;
      end
      ST_MUL: begin
        pa_q     <= {pa_q[ProdW-2:0], 1'b0} + (mag_az_q[MagW-1] ? ProdW'(elap_q) : '0);
        pe_q     <= {pe_q[ProdW-2:0], 1'b0} + (mag_el_q[MagW-1] ? ProdW'(elap_q) : '0);
        mag_az_q <= {mag_az_q[MagW-2:0], 1'b0};
        mag_el_q <= {mag_el_q[MagW-2:0], 1'b0};
      end
      ST_DIV: begin
        pa_q <= {pa_q[ProdW-2:0], 1'b0};
        pe_q <= {pe_q[ProdW-2:0], 1'b0};
        ra_q <= qa_bit ? ra_sh - {1'b0, span_q} : ra_sh;
        re_q <= qe_bit ? re_sh - {1'b0, span_q} : re_sh;
        sa_q <= sa_q | qa_q[QuoW-1];
        se_q <= se_q | qe_q[QuoW-1];
        qa_q <= {qa_q[QuoW-2:0], qa_bit};
        qe_q <= {qe_q[QuoW-2:0], qe_bit};
      end
      ST_SUM: begin
        pend_az_q    <= fit_sum(base_az_q, neg_az_q, qa_q, sa_q, div_q);
        pend_el_q    <= fit_sum(base_el_q, neg_el_q, qe_q, se_q, div_q);
        pend_kind_q  <= kind_q;
        pend_still_q <= still_q;
      end
      ST_RESULT: begin
        if (out_free) begin
          oaz_q    <= pend_az_q;
          oel_q    <= pend_el_q;
          okind_q  <= pend_kind_q;
          ostill_q <= pend_still_q;
          orun_q   <= stab_q;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== tb/sv/tb_timestamped_angle_ring_interpolator.sv =====
// testbench of timestamped_angle_ring_interpolator: directed and random requests
// are checked against a predictor of the sample ring kept in the testbench
// depends on tari_pkg, tari_req_if, tari_rsp_if and the block itself
module tb_timestamped_angle_ring_interpolator;
  import tari_pkg::*;

  localparam int unsigned Depth = 32;
  localparam longint unsigned CycleLimit = 3000000;

  typedef struct packed {
    logic                is_query;
    logic [TimeW-1:0]    stamp;
    logic [AngW-1:0]     az;
    logic [AngW-1:0]     el;
    logic [RangeW-1:0]   rng;
  } angle_req_t;

  typedef struct packed {
    logic [AngW-1:0]   az;
    logic [AngW-1:0]   el;
    logic [1:0]        fit;
    logic              still;
    logic [CountW-1:0] run;
  } angle_rsp_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic pready;

  tari_req_if req ();
  tari_rsp_if rsp ();

  timestamped_angle_ring_interpolator #(.RING_DEPTH(Depth)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rsp_o   (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  longint unsigned smp_time [Depth];
  longint          smp_az   [Depth];
  longint          smp_el   [Depth];
  int unsigned     wr_slot;
  bit              ring_wrapped;
  longint unsigned prev_range;
  longint unsigned run_count;
  longint unsigned cfg_latency;
  longint unsigned cfg_window;
  longint unsigned cfg_limit;

  angle_rsp_t fit_q[$];
  int unsigned errors;
  int unsigned n_query, n_record, n_settings;
  longint unsigned cycles;
  bit no_idle;
  int unsigned hold_left;
  int unsigned stall_left;
  longint unsigned t_cur;
  longint last_az, last_el;
  longint unsigned last_rng;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t timeout with %0d results outstanding", $time, fit_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int unsigned gap_len();
    if (no_idle) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic longint scale_off(longint delta, longint unsigned elapsed,
                                       longint unsigned span);
    logic [127:0] prod;
    logic [127:0] q;
    longint unsigned mag;
    mag = (delta < 0) ? longint'(-delta) : longint'(delta);
    prod = 128'(mag) * 128'(elapsed);
    q = prod / 128'(span);
    if (q > (128'd1 << 33)) q = 128'd1 << 33;
    return (delta < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic logic [AngW-1:0] sat_angle(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic bit step_small(longint da, longint de);
    longint unsigned ma, me;
    ma = (da < 0) ? longint'(-da) : longint'(da);
    me = (de < 0) ? longint'(-de) : longint'(de);
    if (ma >= 64'h80000000 || me >= 64'h80000000) return 1'b0;
    return (ma * ma + me * me) <= cfg_limit;
  endfunction

  function automatic angle_rsp_t predict_fit(angle_req_t it);
    angle_rsp_t r;
    longint unsigned st, md, t0, t1, span;
    longint d, az, el;
    int unsigned n, start, inew, ip, i0, i1;
    bit found;
    r = '0;
    st = 64'(it.stamp);
    az = 0;
    el = 0;
    if (!it.is_query) begin
      d = longint'(64'(it.rng)) - longint'(prev_range);
      md = (d < 0) ? longint'(-d) : longint'(d);
      if (md < cfg_window) begin
        if (run_count < 64'hffffffff) run_count++;
      end else begin
        run_count = 0;
      end
      prev_range = 64'(it.rng);
      smp_time[wr_slot] = (st >= cfg_latency) ? st - cfg_latency : 0;
      smp_az[wr_slot] = longint'(signed'(it.az));
      smp_el[wr_slot] = longint'(signed'(it.el));
      wr_slot++;
      if (wr_slot >= Depth) begin
        wr_slot = 0;
        ring_wrapped = 1'b1;
      end
    end else begin
      n = ring_wrapped ? Depth : wr_slot;
      start = ring_wrapped ? wr_slot : 0;
      found = 1'b0;
      r.still = 1'b1;
      if (n == 0) begin
        r.fit = FIT_EMPTY;
      end else begin
        inew = (start + n - 1) % Depth;
        for (int k = 1; k < n; k++) begin
          i0 = (start + k - 1) % Depth;
          i1 = (start + k) % Depth;
          t0 = smp_time[i0];
          t1 = smp_time[i1];
          if (!step_small(smp_az[i1] - smp_az[i0], smp_el[i1] - smp_el[i0])) r.still = 1'b0;
          if (t0 <= st && st <= t1) begin
            found = 1'b1;
            if (t1 == t0) begin
              az = smp_az[i1];
              el = smp_el[i1];
            end else begin
              az = smp_az[i0] + scale_off(smp_az[i1] - smp_az[i0], st - t0, t1 - t0);
              el = smp_el[i0] + scale_off(smp_el[i1] - smp_el[i0], st - t0, t1 - t0);
            end
          end
        end
        if (found) begin
          r.fit = FIT_INTERP;
        end else if (n >= 2 && st > smp_time[inew]) begin
          ip = (start + n - 2) % Depth;
          r.fit = FIT_EXTRAP;
          az = smp_az[inew];
          el = smp_el[inew];
          if (smp_time[inew] > smp_time[ip]) begin
            span = smp_time[inew] - smp_time[ip];
            az += scale_off(smp_az[inew] - smp_az[ip], st - smp_time[inew], span);
            el += scale_off(smp_el[inew] - smp_el[ip], st - smp_time[inew], span);
          end
        end else begin
          r.fit = FIT_HOLD;
          az = smp_az[inew];
          el = smp_el[inew];
        end
      end
      r.az = sat_angle(az);
      r.el = sat_angle(el);
    end
    r.run = run_count[31:0];
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    angle_rsp_t exp_r;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (fit_q.size() == 0) begin
        $display("%0t unexpected result az %h", $time, rsp.azimuth_out);
        errors++;
      end else begin
        exp_r = fit_q[0];
        fit_q.delete(0);
        if (rsp.azimuth_out !== exp_r.az) begin
          $display("%0t azimuth exp %h got %h", $time, exp_r.az, rsp.azimuth_out);
          errors++;
        end
        if (rsp.elevation_out !== exp_r.el) begin
          $display("%0t elevation exp %h got %h", $time, exp_r.el, rsp.elevation_out);
          errors++;
        end
        if (rsp.fit_kind !== exp_r.fit) begin
          $display("%0t fit_kind exp %0d got %0d", $time, exp_r.fit, rsp.fit_kind);
          errors++;
        end
        if (rsp.is_still !== exp_r.still) begin
          $display("%0t is_still exp %0d got %0d", $time, exp_r.still, rsp.is_still);
          errors++;
        end
        if (rsp.stable_run !== exp_r.run) begin
          $display("%0t stable_run exp %0d got %0d", $time, exp_r.run, rsp.stable_run);
          errors++;
        end
      end
    end
  end

  // result ready with random stalls and long hold-offs
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        rsp.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        rsp.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) stall_left = gap_len();
      end
    end
  end

  task automatic send_req(angle_req_t it);
    int unsigned g;
    angle_rsp_t exp_p;
    @(negedge clk_i);
    req.valid        <= 1'b1;
    req.req_type     <= it.is_query;
    req.stamp        <= it.stamp;
    req.azimuth_in   <= it.az;
    req.elevation_in <= it.el;
    req.range_in     <= it.rng;
    do @(posedge clk_i); while (!req.ready);
    exp_p = predict_fit(it);
    fit_q = {fit_q, exp_p};
    if (it.is_query) n_query++;
    else n_record++;
    g = gap_len();
    if (g > 0) begin
      @(negedge clk_i);
      req.valid <= 1'b0;
      repeat (g - 1) @(negedge clk_i);
    end
  endtask

  task automatic record(longint unsigned stamp, logic [31:0] az, logic [31:0] el,
                        logic [30:0] rng);
    send_req(angle_req_t'{1'b0, stamp[47:0], az, el, rng});
  endtask

  task automatic query(longint unsigned stamp);
    send_req(angle_req_t'{1'b1, stamp[47:0], $urandom(), $urandom(), 31'($urandom())});
  endtask

  task automatic drain();
    @(negedge clk_i);
    req.valid <= 1'b0;
    while (fit_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [DataW-1:0] val);
    logic [DataW-1:0] rd_exp;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(idx) << 3;
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    case (idx)
      REG_LATENCY: cfg_latency = val & 64'hffffff;
      REG_WINDOW:  cfg_window  = val & 64'h7fffffff;
      REG_LIMIT:   cfg_limit   = val & 64'h3fffffffffffffff;
      default: ;
    endcase
    rd_exp = (idx == REG_LATENCY) ? cfg_latency :
             (idx == REG_WINDOW) ? cfg_window : cfg_limit;
    if (prdata !== rd_exp) begin
      $display("%0t register %0d read exp %h got %h", $time, idx, rd_exp, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(logic [DataW-1:0] lat, logic [DataW-1:0] win,
                            logic [DataW-1:0] lim);
    drain();
    write_reg(REG_LATENCY, lat);
    write_reg(REG_WINDOW, win);
    write_reg(REG_LIMIT, lim);
    n_settings++;
  endtask

  task automatic test_empty_ring();
    query(0);
    query(48'hffffffffffff);
    record(5, 32'h00010000, 32'hffff0000, 31'd0);
    query(0);
    query(100);
  endtask

  task automatic test_fit_kinds();
    longint unsigned b;
    b = cfg_latency;
    record(b + 1000, 32'h0, 32'h0, 31'd100);
    record(b + 2000, 32'h03e80000, 32'hfc180000, 31'd200);
    query(1500);
    query(1000);
    query(5000);
    query(10);
    record(b + 2000, 32'h07d00000, 32'h00000100, 31'h7fffffff);
    query(2000);
    query(9000);
    record(b + 3000, 32'h80000000, 32'h7fffffff, 31'd0);
    record(b + 3001, 32'h7fffffff, 32'h80000000, 31'd0);
    query(1000000);
    query(3000);
    query(48'hffffffffffff);
  endtask

  task automatic rand_item();
    angle_req_t it;
    longint q;
    int unsigned r;
    r = $urandom_range(0, 99);
    it = '0;
    if (r < 55) begin
      if ($urandom_range(0, 29) == 0) t_cur = {$urandom_range(0, 32'hffff), $urandom()};
      else if ($urandom_range(0, 7) != 0) t_cur += $urandom_range(1, 2000);
      if ($urandom_range(0, 29) == 0) begin
        last_az = longint'(signed'(32'($urandom())));
        last_el = longint'(signed'(32'($urandom())));
      end else begin
        last_az = longint'(signed'(32'(last_az + $urandom_range(0, 1000) - 500)));
        last_el = longint'(signed'(32'(last_el + $urandom_range(0, 1000) - 500)));
      end
      if ($urandom_range(0, 9) == 0) last_rng = 31'($urandom());
      else last_rng = 31'(last_rng + $urandom_range(0, 13107200) - 6553600);
      it = '{1'b0, t_cur[47:0], last_az[31:0], last_el[31:0], last_rng[30:0]};
    end else if (r < 90) begin
      q = longint'(t_cur) - longint'(cfg_latency) + $urandom_range(0, 7000) - 4000;
      if (q < 0) q = 0;
      it = '{1'b1, q[47:0], 32'($urandom()), 32'($urandom()), 31'($urandom())};
    end else begin
      it = '{1'($urandom()), {16'($urandom()), 32'($urandom())}, 32'($urandom()),
             32'($urandom()), 31'($urandom())};
    end
    send_req(it);
  endtask

  task automatic test_random(int unsigned count);
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) no_idle = ($urandom_range(0, 3) == 0);
      rand_item();
    end
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_left = 500;
    for (int i = 0; i < 8; i++) begin
      if (i % 2 == 0) query(t_cur - cfg_latency);
      else rand_item();
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    n_query = 0;
    n_record = 0;
    n_settings = 1;
    no_idle = 1'b0;
    hold_left = 0;
    stall_left = 0;
    for (int i = 0; i < Depth; i++) begin
      smp_time[i] = 0;
      smp_az[i] = 0;
      smp_el[i] = 0;
    end
    wr_slot = 0;
    ring_wrapped = 1'b0;
    prev_range = 0;
    run_count = 0;
    cfg_latency = 64'(LatencyReset);
    cfg_window = 64'(WindowReset);
    cfg_limit = 64'(LimitReset);
    t_cur = 64'h1000000 + $urandom_range(0, 100000);
    last_az = 0;
    last_el = 0;
    last_rng = 0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req.valid = 1'b0;
    req.req_type = 1'b0;
    req.stamp = '0;
    req.azimuth_in = '0;
    req.elevation_in = '0;
    req.range_in = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (4) @(negedge clk_i);

    test_empty_ring();
    test_fit_kinds();
    test_random(300);
    test_backpressure();
    set_config(0, 0, 0);
    test_fit_kinds();
    test_random(300);
    set_config(64'hffffff, 64'h7fffffff, 64'h3fffffffffffffff);
    t_cur += 64'h1000000;
    test_random(300);
    set_config(64'(LatencyReset), 64'(WindowReset), 64'd2000000);
    test_backpressure();
    test_random(350);

    drain();
    repeat (400) @(posedge clk_i);
    $display("run covered %0d queries and %0d records under %0d register settings",
             n_query, n_record, n_settings);
    $display("checked empty, hold, interpolate, extrapolate, zero span and backpressure");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
